[rtl/core/key_press_duration_capture_macros.svh]
// ----------------------------------------------------------------------------
// Key press duration capture: assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef KEY_PRESS_DURATION_CAPTURE_MACROS_SVH
`define KEY_PRESS_DURATION_CAPTURE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define KPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kpd assertion failed");

// Next-cycle implication checked outside reset.
`define KPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kpd assertion failed");

`endif

[rtl/core/kpd_pkg.sv]
// ----------------------------------------------------------------------------
// Key press duration capture package
// Widths, codes and state type shared by the capture modules.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int FRAME_BITS_DEF = 24;
  localparam int COLUMNS_DEF    = 4;
  localparam int RATE_W         = 10;
  localparam int MS_W           = 34;
  localparam int KEY_W          = 4;
  localparam int COL_W          = 2;
  localparam int KIND_W         = 2;
  localparam logic [RATE_W-1:0] RATE_RESET = 10'd60;
  localparam int MS_PER_S       = 1000;

  // Result kinds.
  localparam logic [KIND_W-1:0] RK_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] RK_FINAL = 2'd1;
  localparam logic [KIND_W-1:0] RK_ERROR = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_GAP,
    ST_GAP_WAIT,
    ST_EMIT,
    ST_END_CLOSE,
    ST_END_WAIT,
    ST_FINAL,
    ST_FINAL_WAIT,
    ST_FINAL_EMIT,
    ST_ERROR
  } kpd_state_t;

  // Request to the shared conversion unit.
  typedef struct packed {
    logic        start;
    logic [31:0] frames;
    logic [9:0]  carry;
  } kpd_conv_req_t;

  // Response of the shared conversion unit.
  typedef struct packed {
    logic            busy;
    logic            done;
    logic [MS_W-1:0] ms;
    logic [9:0]      carry;
  } kpd_conv_rsp_t;

endpackage

[rtl/core/kpd_conv.sv]
// ----------------------------------------------------------------------------
// Frame to millisecond converter
// Computes f*(1000/fps) + (f*(1000%fps)+carry)/fps by restoring division,
// one quotient bit per cycle; 1000/fps is worked out by the same steps at the
// start of every conversion.
// ----------------------------------------------------------------------------
module kpd_conv (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [9:0]             fps,
  input  kpd_pkg::kpd_conv_req_t req,
  output kpd_pkg::kpd_conv_rsp_t rsp
);
  import kpd_pkg::*;

  // Dividend f*r + carry is below 2^32*1000 + 1000, so 42 bits suffice.
  localparam int DW = 42;
  localparam int CW = 6;

  typedef enum logic [1:0] {CV_IDLE, CV_RATE, CV_MUL, CV_DIV} cv_state_t;

  cv_state_t         st_r, st_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DW-1:0]     num_r, num_nxt;
  logic [10:0]       rem_r, rem_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [31:0]       frames_r, frames_nxt;
  logic [9:0]        carry_r, carry_nxt;
  logic [MS_W-1:0]   base_r, base_nxt;
  logic              done_r, done_nxt;
  logic [9:0]        div;
  logic [10:0]       trial;
  logic              fits;

  assign div   = (fps == 10'd0) ? 10'd1 : fps;
  assign trial = {rem_r[9:0], num_r[DW-1]};
  assign fits  = trial >= {1'b0, div};

  // One restoring-division step per cycle; the multiply has its own state, CV_MUL.
  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    frames_nxt = frames_r;
    carry_nxt = carry_r;
    base_nxt  = base_r;
    done_nxt  = 1'b0;
    unique case (st_r)
      CV_IDLE: begin
        if (req.start) begin
          frames_nxt = req.frames;
          carry_nxt  = req.carry;
          num_nxt    = DW'(MS_PER_S) << (DW - 10);
          rem_nxt    = '0;
          quo_nxt    = '0;
          cnt_nxt    = CW'(10);
          st_nxt     = CV_RATE;
        end
      end
      CV_RATE: begin
        num_nxt = num_r << 1;
        if (fits) begin
          rem_nxt = trial - {1'b0, div};
          quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt = CV_MUL;
        end
      end
      CV_MUL: begin
        base_nxt  = MS_W'(DW'(frames_r) * DW'(quo_r[9:0]));
        num_nxt   = DW'(frames_r) * DW'(rem_r[9:0]) + DW'(carry_r);
        rem_nxt   = '0;
        quo_nxt   = '0;
        cnt_nxt   = CW'(DW);
        st_nxt    = CV_DIV;
      end
      CV_DIV: begin
        num_nxt = num_r << 1;
        if (fits) begin
          rem_nxt = trial - {1'b0, div};
          quo_nxt = {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[DW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          st_nxt   = CV_IDLE;
          done_nxt = 1'b1;
        end
      end
      default: st_nxt = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CV_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r    <= num_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    frames_r <= frames_nxt;
    carry_r  <= carry_nxt;
    base_r   <= base_nxt;
  end

  // Result stays valid in the registers until the next start.
  assign rsp.busy  = (st_r != CV_IDLE);
  assign rsp.done  = done_r;
  assign rsp.ms    = base_r + MS_W'(quo_r);
  assign rsp.carry = rem_r[9:0];

endmodule

[rtl/core/key_press_duration_capture.sv]
// ----------------------------------------------------------------------------
// Key press duration capture
// Per-column hold/gap timing with a shared frame to millisecond converter.
// ----------------------------------------------------------------------------
// Each hold, gap or start-delay conversion runs on the one shared divider
// in 10 steps for 1000/fps, a multiply and 42 quotient steps, so a frame
// costs up to COLUMNS conversions and end of stream up to 2*COLUMNS
// conversions. The input is not ready while an item is in work; each
// result waits in the output register until transferred.
module key_press_duration_capture #(
  parameter int FRAME_BITS = kpd_pkg::FRAME_BITS_DEF,
  parameter int COLUMNS    = kpd_pkg::COLUMNS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [kpd_pkg::RATE_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [kpd_pkg::KEY_W-1:0]   in_keys,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kpd_pkg::KIND_W-1:0]  out_result_kind,
  output logic [kpd_pkg::COL_W-1:0]   out_column,
  output logic [kpd_pkg::MS_W-1:0]    out_hold_ms,
  output logic [kpd_pkg::MS_W-1:0]    out_gap_ms,
  output logic [kpd_pkg::MS_W-1:0]    out_start_delay_ms,
  output logic                        out_last
);
  import kpd_pkg::*;

  localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

  kpd_state_t st_r, st_nxt;
  logic [RATE_W-1:0]     rate_r;
  logic [FRAME_BITS-1:0] frame_r;
  logic [FRAME_BITS-1:0] press_r   [COLUMNS];
  logic [FRAME_BITS-1:0] release_r [COLUMNS];
  logic [MS_W-1:0]       hold_r    [COLUMNS];
  logic [COLUMNS-1:0]    pend_r;
  logic [9:0]            carry_r   [COLUMNS];
  logic [FRAME_BITS-1:0] first_r   [COLUMNS];
  logic [FRAME_BITS-1:0] earliest_r;
  logic [CIW-1:0]        col_r;
  logic [KEY_W-1:0]      keys_r;
  logic                  end_r;
  logic                  any_r;

  kpd_conv_req_t req;
  kpd_conv_rsp_t rsp;

  logic held;
  logic col_end;
  logic out_free;
  logic out_load;
  logic later_gap;
  logic [COLUMNS+KEY_W-1:0] keys_ext;
  logic [FRAME_BITS-1:0] cur_press;

  kpd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .fps   (rate_r),
    .req   (req),
    .rsp   (rsp)
  );

  assign cur_press = press_r[col_r];
  assign held      = (int'(col_r) < KEY_W) ? keys_r[col_r] : 1'b0;
  assign col_end   = (int'(col_r) == COLUMNS - 1);
  assign out_free  = !out_valid || out_ready;
  assign out_load  = out_free &&
                     (st_r == ST_EMIT || st_r == ST_FINAL_EMIT || st_r == ST_ERROR);
  assign keys_ext  = {{COLUMNS{1'b0}}, keys_r};
  assign in_ready  = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // A later column of this frame that will still emit a hold/gap entry.
  always_comb begin
    later_gap = 1'b0;
    for (int c = 0; c < COLUMNS; c++) begin
      if (c > int'(col_r) && keys_ext[c] && press_r[c] == '0 && pend_r[c]) begin
        later_gap = 1'b1;
      end
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_valid) st_nxt = in_kind ? ST_END_CLOSE : ST_SCAN;
      ST_SCAN: begin
        if (held && cur_press == '0 && pend_r[col_r]) st_nxt = ST_GAP;
        else if (!held && cur_press != '0)             st_nxt = ST_END_WAIT;
        else if (col_end)                              st_nxt = ST_IDLE;
      end
      ST_GAP:      st_nxt = ST_GAP_WAIT;
      ST_GAP_WAIT: if (rsp.done) st_nxt = ST_EMIT;
      ST_EMIT:     if (out_free) st_nxt = col_end ? ST_IDLE : ST_SCAN;
      ST_END_CLOSE: begin
        if (cur_press != '0) st_nxt = ST_END_WAIT;
        else if (col_end)    st_nxt = (any_r || first_r[col_r] == '0) ? ST_ERROR : ST_FINAL;
      end
      ST_END_WAIT: begin
        if (rsp.done) begin
          if (!end_r)       st_nxt = col_end ? ST_IDLE : ST_SCAN;
          else if (col_end) st_nxt = (any_r || first_r[col_r] == '0) ? ST_ERROR : ST_FINAL;
          else              st_nxt = ST_END_CLOSE;
        end
      end
      ST_FINAL:      st_nxt = ST_FINAL_WAIT;
      ST_FINAL_WAIT: if (rsp.done) st_nxt = ST_FINAL_EMIT;
      ST_FINAL_EMIT: if (out_free) st_nxt = col_end ? ST_IDLE : ST_FINAL;
      ST_ERROR:      if (out_free) st_nxt = ST_IDLE;
      default:       st_nxt = ST_IDLE;
    endcase
  end

  // Conversion requests to the shared unit.
  always_comb begin
    req.start  = 1'b0;
    req.frames = '0;
    req.carry  = carry_r[col_r];
    unique case (st_r)
      ST_SCAN: begin
        if (!held && cur_press != '0) begin
          req.start  = 1'b1;
          req.frames = 32'(frame_r - cur_press);
        end
      end
      ST_END_CLOSE: begin
        if (cur_press != '0) begin
          req.start  = 1'b1;
          req.frames = 32'(frame_r - cur_press);
        end
      end
      ST_GAP: begin
        req.start  = 1'b1;
        req.frames = 32'(frame_r - release_r[col_r]);
      end
      ST_FINAL: begin
        req.start  = 1'b1;
        req.frames = 32'(first_r[col_r] - earliest_r);
        req.carry  = '0;
      end
      default: ;
    endcase
  end

  // Sequencer and column state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      rate_r     <= RATE_RESET;
      frame_r    <= FRAME_BITS'(1);
      pend_r     <= '0;
      earliest_r <= '0;
      col_r      <= '0;
      end_r      <= 1'b0;
      any_r      <= 1'b0;
      out_valid  <= 1'b0;
      for (int c = 0; c < COLUMNS; c++) begin
        press_r[c]   <= '0;
        release_r[c] <= '0;
        hold_r[c]    <= '0;
        carry_r[c]   <= '0;
        first_r[c]   <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) rate_r <= cfg_data;
      // The output register is loaded when free, else cleared once transferred.
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          col_r  <= '0;
          keys_r <= in_keys;
          end_r  <= in_kind;
          any_r  <= 1'b0;
        end
        ST_SCAN: begin
          if (held && cur_press == '0) begin
            if (!pend_r[col_r]) begin
              press_r[col_r] <= frame_r;
              if (first_r[col_r] == '0) first_r[col_r] <= frame_r;
              if (earliest_r == '0) earliest_r <= frame_r;
            end
          end
          if (st_nxt == ST_IDLE || (st_nxt == ST_SCAN)) begin
            col_r <= col_r + 1'b1;
          end
          if (st_nxt == ST_IDLE && frame_r != FRAME_MAX) frame_r <= frame_r + 1'b1;
        end
        ST_GAP_WAIT: begin
          if (rsp.done) carry_r[col_r] <= rsp.carry;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_result_kind    <= RK_ENTRY;
            out_column         <= COL_W'(col_r);
            out_hold_ms        <= hold_r[col_r];
            out_gap_ms         <= rsp.ms;
            out_start_delay_ms <= '0;
            out_last           <= !later_gap;
            pend_r[col_r]      <= 1'b0;
            press_r[col_r]     <= frame_r;
            if (first_r[col_r] == '0) first_r[col_r] <= frame_r;
            if (earliest_r == '0) earliest_r <= frame_r;
            col_r <= col_r + 1'b1;
            if (col_end && frame_r != FRAME_MAX) frame_r <= frame_r + 1'b1;
          end
        end
        ST_END_CLOSE: begin
          if (first_r[col_r] == '0) any_r <= 1'b1;
          if (cur_press == '0 && !col_end) col_r <= col_r + 1'b1;
          if (cur_press == '0 && col_end) col_r <= '0;
        end
        ST_END_WAIT: begin
          if (rsp.done) begin
            hold_r[col_r]    <= rsp.ms;
            carry_r[col_r]   <= rsp.carry;
            pend_r[col_r]    <= 1'b1;
            release_r[col_r] <= frame_r;
            press_r[col_r]   <= '0;
            if (end_r) begin
              if (first_r[col_r] == '0) any_r <= 1'b1;
              col_r <= col_end ? '0 : col_r + 1'b1;
            end else begin
              col_r <= col_r + 1'b1;
              if (col_end && frame_r != FRAME_MAX) frame_r <= frame_r + 1'b1;
            end
          end
        end
        ST_FINAL_EMIT: begin
          if (out_free) begin
            out_result_kind    <= RK_FINAL;
            out_column         <= COL_W'(col_r);
            out_hold_ms        <= hold_r[col_r];
            out_gap_ms         <= '0;
            out_start_delay_ms <= rsp.ms;
            out_last           <= col_end;
            col_r              <= col_r + 1'b1;
          end
        end
        ST_ERROR: begin
          if (out_free) begin
            out_result_kind    <= RK_ERROR;
            out_column         <= '0;
            out_hold_ms        <= '0;
            out_gap_ms         <= '0;
            out_start_delay_ms <= '0;
            out_last           <= 1'b1;
          end
        end
        default: ;
      endcase
      // End of stream returns the stream state to its reset value.
      if ((st_r == ST_FINAL_EMIT && out_free && col_end) ||
          (st_r == ST_ERROR && out_free)) begin
        frame_r    <= FRAME_BITS'(1);
        pend_r     <= '0;
        earliest_r <= '0;
        for (int c = 0; c < COLUMNS; c++) begin
          press_r[c]   <= '0;
          release_r[c] <= '0;
          hold_r[c]    <= '0;
          carry_r[c]   <= '0;
          first_r[c]   <= '0;
        end
      end
    end
  end

endmodule

[rtl/core/kpd_checker.sv]
// ----------------------------------------------------------------------------
// Key press duration capture checker
// Port-level properties of the capture block, bound to the top level.
// ----------------------------------------------------------------------------
`include "key_press_duration_capture_macros.svh"

module kpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_result_kind,
  input logic       out_last
);
  import kpd_pkg::*;

  // An error result is always the only one for its item.
  `KPD_ASSERT_IMP(a_err_last, out_valid && out_result_kind == RK_ERROR, out_last)
  // Result kind is never the unused code.
  `KPD_ASSERT_IMP(a_kind_ok, out_valid, out_result_kind != 2'd3)
  // A taken item closes the input until the work is done.
  `KPD_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready)
  // A stalled result holds.
  `KPD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)

endmodule

bind key_press_duration_capture kpd_checker u_kpd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_last        (out_last)
);
